// ===== sv/sgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and the tangent threshold table for the Sobel gradient block.
// ----------------------------------------------------------------------------
package sgm_pkg;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [10:0] row;
        logic [10:0] column;
        logic [7:0]  grad_x_abs;
        logic [7:0]  grad_y_abs;
        logic [7:0]  magnitude;
        logic [8:0]  angle;
    } t_result;

    // Request to the magnitude / direction unit
    typedef struct packed {
        logic       start;
        logic [9:0] ax;
        logic [9:0] ay;
        logic       gx_zero;
        logic       gy_zero;
        logic       neg;
    } t_grad_req;

    localparam int TAN_N = 90;
    localparam logic [7:0] TAN_LAST = 8'd89;
    localparam logic [8:0] DEG_90   = 9'd90;
    localparam logic [8:0] DEG_360  = 9'd360;
    localparam logic [20:0] SQ_LIMIT = 21'd65536;

    typedef logic [21:0] t_tan_tbl [0:TAN_N-1];

    // round(tan(k / 57.3) * 2^16), evaluated at elaboration
    function automatic t_tan_tbl build_tan_table();
        t_tan_tbl t;
        real v;
        t[0] = '0;
        for (int k = 1; k < TAN_N; k++) begin
            v = $tan(k / 57.3) * 65536.0;
            t[k] = 22'($rtoi($floor(v + 0.5)));
        end
        return t;
    endfunction

    localparam t_tan_tbl TAN_Q16 = build_tan_table();

endpackage

// ===== sv/sobel_gradient_magnitude_angle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_angle
// 3x3 Sobel gradient with magnitude and direction over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one pixel per
//   transfer in raster order; frame_start restarts the row/column counters.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries one
//   result per interior pixel: centre row/column, |gx|, |gy|, magnitude
//   and angle in degrees. Border centres give no result.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the row
//   width; it is always ready and should only be written while idle.
// Timing:
//   One pixel is in flight at a time. A pixel that completes a window has
//   its result presented after the line-store read and Sobel step, the
//   request handoff, eight iterations of the shared magnitude/angle unit
//   (one result bit each), the done strobe and the output-register load.
//   The next pixel can be taken in the cycle after that load. A pixel with
//   no result goes back to idle straight after its read step.
//   The output register holds a result while the receiver stalls; the next
//   pixel is still taken and processed until its own result needs that reg.
// Reset: counters, window and width (640) are cleared; the line store has no
//   clearing pass and is valid once two full rows have been written.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_angle
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_pix_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    r_state;
    logic [11:0]   r_fw;
    logic [CW-1:0] r_col, r_c, c_eff;
    logic [RW-1:0] r_row, r_r, row_eff;
    logic [7:0]    r_pix;
    logic [7:0]    r_win [0:5];
    logic [CW:0]   w_eff, c_next;
    logic [15:0]   rd_data;
    logic [7:0]    top, mid;
    logic [10:0]   sum_r, sum_l, sum_t, sum_b;
    logic [11:0]   gx, gy;
    logic [9:0]    ax, ay;
    logic          emit, accept;
    t_grad_req     r_req;
    logic          g_done;
    logic [7:0]    g_mag;
    logic [8:0]    g_ang;
    logic [10:0]   r_res_row, r_res_col;
    logic          r_out_valid;
    t_result       r_out;

    assign accept      = (r_state == S_IDLE) && i_in_valid;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign c_eff   = i_in_data.frame_start ? '0 : r_col;
    assign row_eff = i_in_data.frame_start ? '0 : r_row;

    // Effective width, clamped to 3..MAX_WIDTH
    always_comb begin
        if (r_fw < 12'd3) begin
            w_eff = (CW+1)'(3);
        end else if ({20'b0, r_fw} > 32'(MAX_WIDTH)) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(r_fw);
        end
    end

    sgm_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line (
        .i_clk    (i_clk),
        .i_rd_en  (accept),
        .i_rd_addr(c_eff),
        .o_rd_data(rd_data),
        .i_wr_en  (r_state == S_READ),
        .i_wr_addr(r_c),
        .i_wr_data({mid, r_pix})
    );

    // Sobel on the window: left column r_win[0..2], middle r_win[3..5],
    // right column = line store pair plus the incoming pixel.
    always_comb begin
        top    = rd_data[15:8];
        mid    = rd_data[7:0];
        sum_r  = {3'b0, top} + {2'b0, mid, 1'b0} + {3'b0, r_pix};
        sum_l  = {3'b0, r_win[0]} + {2'b0, r_win[1], 1'b0} + {3'b0, r_win[2]};
        sum_t  = {3'b0, r_win[0]} + {2'b0, r_win[3], 1'b0} + {3'b0, top};
        sum_b  = {3'b0, r_win[2]} + {2'b0, r_win[5], 1'b0} + {3'b0, r_pix};
        gx     = {1'b0, sum_r} - {1'b0, sum_l};
        gy     = {1'b0, sum_t} - {1'b0, sum_b};
        ax     = gx[11] ? 10'(-gx) : gx[9:0];
        ay     = gy[11] ? 10'(-gy) : gy[9:0];
        emit   = (r_r >= RW'(2)) && (r_c >= CW'(2));
        c_next = {1'b0, r_c} + (CW+1)'(1);
    end

    sgm_grad_unit u_grad (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .o_done (g_done),
        .o_mag  (g_mag),
        .o_angle(g_ang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fw        <= 12'd640;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            r_req.start <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            // start pulses for one cycle when a window completes
            r_req.start <= (r_state == S_READ) && emit;
            if (i_cfg_valid) begin
                r_fw <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pix   <= i_in_data.pixel;
                        r_c     <= c_eff;
                        r_r     <= row_eff;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_win[0] <= r_win[3];
                    r_win[1] <= r_win[4];
                    r_win[2] <= r_win[5];
                    r_win[3] <= top;
                    r_win[4] <= mid;
                    r_win[5] <= r_pix;
                    if (c_next >= w_eff) begin
                        r_col <= '0;
                        if (r_r < RW'(MAX_HEIGHT - 1)) begin
                            r_row <= r_r + RW'(1);
                        end else begin
                            r_row <= r_r;
                        end
                    end else begin
                        r_col <= c_next[CW-1:0];
                        r_row <= r_r;
                    end
                    r_req.ax      <= ax;
                    r_req.ay      <= ay;
                    r_req.gx_zero <= (gx == 12'd0);
                    r_req.gy_zero <= (gy == 12'd0);
                    r_req.neg     <= (gx[11] != gy[11]);
                    r_res_row     <= 11'(r_r - RW'(1));
                    r_res_col     <= 11'(r_c - CW'(1));
                    if (emit) begin
                        r_state <= S_CALC;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CALC: begin
                    // grad unit holds mag/angle until its next run completes
                    if (g_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // load only once the previous result has left
                    if (!r_out_valid || i_out_ready) begin
                        r_out.row        <= r_res_row;
                        r_out.column     <= r_res_col;
                        r_out.grad_x_abs <= (r_req.ax > 10'd255) ? 8'd255 : r_req.ax[7:0];
                        r_out.grad_y_abs <= (r_req.ay > 10'd255) ? 8'd255 : r_req.ay[7:0];
                        r_out.magnitude  <= g_mag;
                        r_out.angle      <= g_ang;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/sgm_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_line_buf
// Two-line sample store; each entry holds {line r-2, line r-1} for a column.
// ----------------------------------------------------------------------------
module sgm_line_buf #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    output logic [15:0]                  o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [15:0]                  i_wr_data
);

    logic [15:0] mem [0:MAX_WIDTH-1];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sgm_grad_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_grad_unit
// Iterative magnitude (bit-serial square root) and direction (binary search
// over the tangent table), one bit per cycle.
// ----------------------------------------------------------------------------
module sgm_grad_unit
    import sgm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_grad_req i_req,
    output logic      o_done,
    output logic [7:0] o_mag,
    output logic [8:0] o_angle
);

    logic        r_busy, r_done;
    logic [2:0]  r_step;
    logic [7:0]  r_res, n_res;
    logic [7:0]  r_lo, n_lo;
    logic [20:0] r_sum;
    logic [9:0]  r_ax, r_ay;
    logic        r_gxz, r_gyz, r_neg;
    logic [7:0]  r_mag;
    logic [8:0]  r_ang, n_ang;
    logic [7:0]  trial, cand;
    logic [15:0] trial_sq;
    logic [31:0] thr_prod;
    logic [8:0]  base;

    always_comb begin
        trial    = r_res | (8'd1 << r_step);
        trial_sq = trial * trial;
        n_res    = ({5'b0, trial_sq} <= r_sum) ? trial : r_res;
        cand     = r_lo + (8'd1 << r_step);
        thr_prod = {10'b0, TAN_Q16[cand[6:0]]} * {22'b0, r_ax};
        n_lo     = r_lo;
        if (r_step != 3'd7 && cand <= TAN_LAST
                && {6'b0, r_ay, 16'b0} >= thr_prod) begin
            n_lo = cand;
        end
        if (r_gxz) begin
            base = r_gyz ? 9'd0 : DEG_90;
        end else begin
            base = {1'b0, n_lo};
        end
        n_ang = (base != 9'd0 && r_neg) ? DEG_360 - base : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_step == 3'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == 3'd0) begin
                r_busy <= 1'b0;
            end
        end
        if (i_req.start) begin
            r_sum  <= {1'b0, 10'b0, i_req.ax} * {11'b0, i_req.ax}
                    + {1'b0, 10'b0, i_req.ay} * {11'b0, i_req.ay};
            r_ax   <= i_req.ax;
            r_ay   <= i_req.ay;
            r_gxz  <= i_req.gx_zero;
            r_gyz  <= i_req.gy_zero;
            r_neg  <= i_req.neg;
            r_step <= 3'd7;
            r_res  <= '0;
            r_lo   <= '0;
        end else if (r_busy) begin
            r_res  <= n_res;
            r_lo   <= n_lo;
            r_step <= r_step - 3'd1;
            if (r_step == 3'd0) begin
                r_mag <= (r_sum >= SQ_LIMIT) ? 8'd255 : n_res;
                r_ang <= n_ang;
            end
        end
    end

    assign o_done  = r_done;
    assign o_mag   = r_mag;
    assign o_angle = r_ang;

endmodule

// ===== tb/sobel_gradient_magnitude_angle_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_angle_tb
// Self-checking bench for the streaming Sobel magnitude/angle block.
// A driver feeds pixels from a backlog, a monitor checks every result against
// a cycle-free software copy of the block (line buffers, window, tangent
// thresholds). Covers width clamping, missing frame starts, frame restarts,
// random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_angle_tb;
    import sgm_pkg::*;

    localparam int MAXW = 2048;
    localparam int MAXH = 2048;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int CFG_IDX_WIDTH = 0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_pix_in     in_data;
    logic        out_valid;
    logic        out_ready;
    t_result     out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;

    sobel_gradient_magnitude_angle u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Clock, 10 ns period
    // ------------------------------------------------------------------------
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Shadow of the block: state, width register and tangent thresholds
    // ------------------------------------------------------------------------
    logic [7:0]  ln_store [0:2*MAXW-1];
    logic [7:0]  win [0:5];
    int unsigned col_cnt;
    int unsigned row_cnt;
    logic [11:0] width_reg;
    logic [31:0] tan_thr [0:89];

    t_pix_in pixel_backlog [$];
    t_result grad_expect [$];

    int  err_cnt;
    bit  tx_idle_en;    // sender gaps on/off for the current stretch
    bit  rx_idle_en;    // receiver stalls on/off
    int  hold_req_cnt;  // bumped to request one long receiver hold

    // (a * b) >> 60 with a full 128-bit product
    function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Thresholds round(tan(k/57.3) * 2^16) from Q60 sin/cos series
    task automatic fill_tan_thresholds();
        logic [63:0] q, r, m, x, x2, ts, tc, s40, c40;
        longint      s, c;
        q = 64'h1000_0000_0000_0000 / 64'd573;
        r = 64'h1000_0000_0000_0000 % 64'd573;
        tan_thr[0] = '0;
        for (int k = 1; k < 90; k++) begin
            m  = 64'(10 * k);
            x  = m * q + (m * r) / 64'd573;
            x2 = q60_mul(x, x);
            ts = x;
            tc = 64'h1000_0000_0000_0000;
            s  = longint'(x);
            c  = longint'(tc);
            for (int n = 1; n <= 20; n++) begin
                ts = q60_mul(ts, x2) / 64'((2 * n) * (2 * n + 1));
                tc = q60_mul(tc, x2) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            s40 = 64'(s) >> 16;
            c40 = 64'(c) >> 16;
            if (c40 == 0) c40 = 1;
            tan_thr[k] = 32'(((s40 << 17) + c40) / (2 * c40));
        end
    endtask

    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned res, bitv;
        res  = 0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] clip255(int unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic int unsigned eff_width(logic [11:0] w);
        if (w < 3) return 3;
        if (w > MAXW) return MAXW;
        return 32'(w);
    endfunction

    // Advance the shadow by one pixel; queue the result it completes, if any
    task automatic sobel_predict(t_pix_in px);
        int unsigned wdt, c, rr, top, mid, ax, ay, ang;
        int          gx, gy;
        t_result     res;
        wdt = eff_width(width_reg);
        if (px.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c   = col_cnt % MAXW;
        rr  = row_cnt;
        top = 32'(ln_store[MAXW + c]);
        mid = 32'(ln_store[c]);
        ln_store[MAXW + c] = mid[7:0];
        ln_store[c]        = px.pixel;

        if (rr >= 2 && c >= 2) begin
            gx = (int'(top) + 2 * int'(mid) + int'(px.pixel))
               - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
            gy = (int'(win[0]) + 2 * int'(win[3]) + int'(top))
               - (int'(win[2]) + 2 * int'(win[5]) + int'(px.pixel));
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            ang = 0;
            if (gx == 0) begin
                ang = (gy == 0) ? 0 : 90;
            end else begin
                for (int k = 1; k < 90; k++)
                    if (64'(ay) * 64'd65536 >= 64'(tan_thr[k]) * 64'(ax)) ang++;
            end
            // opposite signs fold into the fourth quadrant
            if (ang != 0 && ((gy < 0) != (gx < 0))) ang = 360 - ang;
            res.row        = 11'(rr - 1);
            res.column     = 11'(c - 1);
            res.grad_x_abs = clip255(ax);
            res.grad_y_abs = clip255(ay);
            res.magnitude  = clip255(int_sqrt(ax * ax + ay * ay));
            res.angle      = 9'(ang);
            grad_expect.push_back(res);
        end

        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top[7:0];
        win[4] = mid[7:0];
        win[5] = px.pixel;

        if (c + 1 >= wdt) begin
            col_cnt = 0;
            if (row_cnt < MAXH - 1) row_cnt++;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: prediction on input transfers, checks on output transfers
    // ------------------------------------------------------------------------
    bit in_took;
    bit out_took;
    int unsigned cyc;

    always @(posedge clk) begin
        t_result e;
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end else if (rst_n) begin
            in_took  <= in_valid && in_ready;
            out_took <= out_valid && out_ready;
            if (cfg_valid && cfg_ready) width_reg = cfg_data;
            if (in_valid && in_ready) sobel_predict(in_data);
            if (out_valid && out_ready) begin
                if (grad_expect.size() == 0) begin
                    $error("result transfer with nothing expected: row %0d col %0d",
                           out_data.row, out_data.column);
                    err_cnt++;
                end else begin
                    e = grad_expect.pop_front();
                    if (out_data.row !== e.row) begin
                        $error("row: expected %0d actual %0d", e.row, out_data.row);
                        err_cnt++;
                    end
                    if (out_data.column !== e.column) begin
                        $error("column: expected %0d actual %0d", e.column, out_data.column);
                        err_cnt++;
                    end
                    if (out_data.grad_x_abs !== e.grad_x_abs) begin
                        $error("grad_x_abs: expected %0d actual %0d",
                               e.grad_x_abs, out_data.grad_x_abs);
                        err_cnt++;
                    end
                    if (out_data.grad_y_abs !== e.grad_y_abs) begin
                        $error("grad_y_abs: expected %0d actual %0d",
                               e.grad_y_abs, out_data.grad_y_abs);
                        err_cnt++;
                    end
                    if (out_data.magnitude !== e.magnitude) begin
                        $error("magnitude: expected %0d actual %0d",
                               e.magnitude, out_data.magnitude);
                        err_cnt++;
                    end
                    if (out_data.angle !== e.angle) begin
                        $error("angle: expected %0d actual %0d", e.angle, out_data.angle);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Long receiver hold, counted here so the sender keeps pushing meanwhile
    int hold_seen;
    int hold_left;
    always @(posedge clk) begin
        if (hold_seen != hold_req_cnt) begin
            hold_seen <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: one pixel per transfer, random gap before the next one
    // ------------------------------------------------------------------------
    int gap_left;
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_took) begin
                // hold the offer until it transfers
            end else if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pixel_backlog.size() > 0) begin
                in_data  <= pixel_backlog.pop_front();
                in_valid <= 1'b1;
                gap_left <= tx_idle_en ? $urandom_range(0, 18) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each result transfer
    int stall_left;
    always @(negedge clk) begin
        int s;
        if (rst_n) begin
            s = out_took ? (rx_idle_en ? $urandom_range(0, 18) : 0) : stall_left;
            if (s > 0) begin
                out_ready  <= 1'b0;
                stall_left <= s - 1;
            end else begin
                out_ready  <= (hold_left == 0);
                stall_left <= 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_pixel(logic [7:0] p, bit fs);
        t_pix_in t;
        t.pixel       = p;
        t.frame_start = fs;
        pixel_backlog.push_back(t);
    endtask

    // Block is quiet: backlog drained, no offer open, no result pending
    task automatic wait_drained();
        do @(posedge clk);
        while (pixel_backlog.size() != 0 || in_valid || grad_expect.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(logic [11:0] w);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One frame; style picks random, ramp or binary content.
    // Noise occasionally restarts the frame in the middle.
    task automatic push_frame(int unsigned wdt, int unsigned rows, int style, bit noise);
        int dx, dy, base, v;
        dx   = $urandom_range(0, 40) - 20;
        dy   = $urandom_range(0, 40) - 20;
        base = $urandom_range(0, 255);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < wdt; c++) begin
                case (style)
                    0: v = $urandom_range(0, 255);
                    1: begin
                        v = base + dx * c + dy * r + $urandom_range(0, 2);
                        v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                    end
                    default: v = $urandom_range(0, 1) ? 255 : 0;
                endcase
                push_pixel(8'(v), (r == 0 && c == 0) ||
                                  (noise && $urandom_range(0, 60) == 0));
            end
    endtask

    // Directed pixels for a 3-wide frame: flat, full steps both ways,
    // diagonals and saturating edges.
    localparam logic [7:0] DIR_PIX [0:23] = '{
        8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255,
        8'd0,   8'd0,   8'd0,
        8'd0,   8'd128, 8'd255,
        8'd0,   8'd0,   8'd255,
        8'd255, 8'd0,   8'd0,
        8'd0,   8'd255, 8'd0,
        8'd170, 8'd85,  8'd1
    };

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned w, sent;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        err_cnt      = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        hold_req_cnt = 0;
        hold_seen    = 0;
        hold_left    = 0;
        gap_left     = 0;
        stall_left   = 0;
        in_took      = 1'b0;
        out_took     = 1'b0;
        cyc          = 0;
        col_cnt      = 0;
        row_cnt      = 0;
        width_reg    = 12'd640;
        for (int i = 0; i < 6; i++) win[i] = '0;
        for (int i = 0; i < 2 * MAXW; i++) ln_store[i] = '0;
        fill_tan_thresholds();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Width below range acts as 3; first pixels carry no frame start,
        // a restart sits at the start of the fifth row.
        write_width(CFG_IDX_WIDTH);
        for (int i = 0; i < 24; i++) push_pixel(DIR_PIX[i], i == 12);
        wait_drained();

        // Random frames in phases; width and idling change per phase
        sent = 0;
        for (int ph = 0; sent < 580; ph++) begin
            w = (ph % 5 == 4) ? $urandom_range(1, 2) : $urandom_range(3, 24);
            write_width(12'(w));
            tx_idle_en = (ph % 3 != 0);
            rx_idle_en = (ph % 4 != 1);
            if (ph == 2) hold_req_cnt++;
            for (int f = 0; f < 2; f++) begin
                int unsigned rows;
                rows = $urandom_range(3, 6);
                push_frame(eff_width(12'(w)), rows, $urandom_range(0, 2), (ph % 2 == 1));
                sent += eff_width(12'(w)) * rows;
            end
            wait_drained();
        end

        // Width above range clamps; a short first row streams fast
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_width(12'd4095);
        for (int i = 0; i < 12; i++) push_pixel(8'($urandom_range(0, 255)), i == 0);
        wait_drained();

        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sgm_pkg.sv
sv/sgm_line_buf.sv
sv/sgm_grad_unit.sv
sv/sobel_gradient_magnitude_angle.sv
tb/sobel_gradient_magnitude_angle_tb.sv
